FILE: hdl/tpc_pkg.sv
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared types, widths, register indexes and helpers of the plane clipper.
// ----------------------------------------------------------------------------
package tpc_pkg;

    localparam int CW        = 32;           // coordinate width
    localparam int T_W       = 32;           // fraction bits of t
    localparam int ATTR_W    = 32;
    localparam int DIFF_W    = CW + 1;
    localparam int PROD_W    = 2 * CW;
    localparam int DIST_W    = 2 * CW + 2;
    localparam int MAG_W     = 2 * CW + 1;
    localparam int DEN_W     = 2 * CW + 2;
    localparam int OFF_W     = CW + 1;
    localparam int MUL_W     = CW + T_W;
    localparam int CFG_IDX_W = 8;
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = $clog2(Q_DEPTH);
    localparam int Q_CW      = $clog2(Q_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Y = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Z = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_X  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_Y  = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_Z  = CFG_IDX_W'(5);

    localparam logic signed [CW-1:0] NORMAL_Z_RST = CW'(65536);

    localparam logic signed [CW+1:0] SAT_HI = {3'b000, {(CW-1){1'b1}}};
    localparam logic signed [CW+1:0] SAT_LO = {3'b111, {(CW-1){1'b0}}};

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_vec;

    typedef struct packed {
        logic signed [DIFF_W-1:0] x;
        logic signed [DIFF_W-1:0] y;
        logic signed [DIFF_W-1:0] z;
    } t_dvec;

    typedef struct packed {
        t_vec normal;
        t_vec point;
    } t_plane;

    typedef struct packed {
        t_coord              vertex_a_x;
        t_coord              vertex_a_y;
        t_coord              vertex_a_z;
        t_coord              vertex_b_x;
        t_coord              vertex_b_y;
        t_coord              vertex_b_z;
        t_coord              vertex_c_x;
        t_coord              vertex_c_y;
        t_coord              vertex_c_z;
        logic [ATTR_W-1:0]   attribute;
    } t_in_item;

    typedef struct packed {
        t_coord              out_a_x;
        t_coord              out_a_y;
        t_coord              out_a_z;
        t_coord              out_b_x;
        t_coord              out_b_y;
        t_coord              out_b_z;
        t_coord              out_c_x;
        t_coord              out_c_y;
        t_coord              out_c_z;
        logic [ATTR_W-1:0]   out_attribute;
        logic                last_of_run;
    } t_out_item;

    typedef enum logic [1:0] {
        KIND_PASS = 2'd0,
        KIND_TWO  = 2'd1,
        KIND_ONE  = 2'd2
    } t_kind;

    // Classified triangle. I1 = I(u, b1), I2 = I(a2, b2).
    typedef struct packed {
        t_kind               kind;
        t_vec                u;
        t_vec                w;
        t_vec                b1;
        t_vec                a2;
        t_vec                b2;
        logic [MAG_W-1:0]    da1;
        logic [MAG_W-1:0]    db1;
        logic [MAG_W-1:0]    da2;
        logic [MAG_W-1:0]    db2;
        logic [ATTR_W-1:0]   attr;
    } t_job;

    typedef struct packed {
        t_kind               kind;
        t_vec                u;
        t_vec                w;
        t_vec                b1;
        t_vec                a2;
        t_dvec               d1;
        t_dvec               d2;
        logic [ATTR_W-1:0]   attr;
    } t_ctx;

    typedef struct packed {
        logic [DEN_W-1:0]    rem;
        logic [DEN_W-1:0]    den;
        logic [T_W-1:0]      q;
    } t_div_st;

    typedef struct packed {
        logic                full;
        logic                empty;
        logic [Q_CW-1:0]     count;
    } t_q_stat;

    function automatic t_dvec vsub(t_vec a, t_vec b);
        t_dvec r;
        r.x = DIFF_W'(a.x) - DIFF_W'(b.x);
        r.y = DIFF_W'(a.y) - DIFF_W'(b.y);
        r.z = DIFF_W'(a.z) - DIFF_W'(b.z);
        return r;
    endfunction

    function automatic t_coord sat_coord(logic signed [CW+1:0] v);
        logic signed [CW+1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI;
        end else if (v < SAT_LO) begin
            r = SAT_LO;
        end else begin
            r = v;
        end
        return r[CW-1:0];
    endfunction

endpackage

FILE: hdl/triangle_plane_clipper.sv
// ----------------------------------------------------------------------------
// triangle_plane_clipper
// Clips triangles (signed Q16.16) against a programmable plane. A triangle
// fully inside passes unchanged, one fully outside gives no item, one with
// two inside vertices gives two items and one with one inside vertex gives
// one item; last_of_run marks the final item of each triangle. A new
// triangle is taken every cycle while results leave at one item per cycle,
// the job queue is not full and the output is not stalled; a triangle that
// gives two items holds the single output register until both have left.
// From input to first result a triangle passes three distance stages, the
// job queue, one setup stage, a 32-stage pipelined divider for the edge
// parameter, one scaling multiply and the output register. The user must
// write plane registers only while no triangle is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module triangle_plane_clipper (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  tpc_pkg::t_in_item                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output tpc_pkg::t_out_item                  o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tpc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tpc_pkg::CW-1:0]              i_cfg_data
);

    tpc_pkg::t_plane     r_plane;
    logic                w_push;
    logic                w_pop;
    tpc_pkg::t_job       w_fjob;
    tpc_pkg::t_job       w_qjob;
    tpc_pkg::t_q_stat    w_qstat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= '{normal: '{x: '0, y: '0, z: tpc_pkg::NORMAL_Z_RST},
                         point: '0};
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tpc_pkg::CFG_NORMAL_X: r_plane.normal.x <= i_cfg_data;
                tpc_pkg::CFG_NORMAL_Y: r_plane.normal.y <= i_cfg_data;
                tpc_pkg::CFG_NORMAL_Z: r_plane.normal.z <= i_cfg_data;
                tpc_pkg::CFG_POINT_X:  r_plane.point.x  <= i_cfg_data;
                tpc_pkg::CFG_POINT_Y:  r_plane.point.y  <= i_cfg_data;
                tpc_pkg::CFG_POINT_Z:  r_plane.point.z  <= i_cfg_data;
                default:               r_plane          <= r_plane;
            endcase
        end
    end

    tpc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_plane (r_plane),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_data),
        .i_full  (w_qstat.full),
        .o_push  (w_push),
        .o_job   (w_fjob)
    );

    tpc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_fjob),
        .i_pop   (w_pop),
        .o_job   (w_qjob),
        .o_stat  (w_qstat)
    );

    tpc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_qstat.empty),
        .i_job   (w_qjob),
        .o_pop   (w_pop),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_data)
    );

`ifndef SYNTHESIS
    a_q_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_qstat.full))
        else $error("job queue pushed while full");

    a_q_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_pop && w_qstat.empty))
        else $error("job queue popped while empty");

    a_q_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qstat.count <= tpc_pkg::Q_CW'(tpc_pkg::Q_DEPTH))
        else $error("job queue count out of range");

    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_out_data.last_of_run) |=> o_out_valid)
        else $error("second item of a split triangle missing");
`endif

endmodule

FILE: hdl/tpc_front.sv
// ----------------------------------------------------------------------------
// tpc_front
// Takes triangles, computes exact plane distances and classifies them into
// jobs for the queue. Three stages; fully outside triangles are dropped.
// ----------------------------------------------------------------------------
module tpc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tpc_pkg::t_plane    i_plane,
    input  logic               i_valid,
    output logic               o_ready,
    input  tpc_pkg::t_in_item  i_item,
    input  logic               i_full,
    output logic               o_push,
    output tpc_pkg::t_job      o_job
);

    logic                                 en;
    logic                                 r_s1_v;
    logic                                 r_s2_v;
    logic                                 r_s3_v;
    logic                                 n_s3_v;
    tpc_pkg::t_in_item                    r_s1_item;
    tpc_pkg::t_in_item                    r_s2_item;
    tpc_pkg::t_vec                        in_p [3];
    tpc_pkg::t_vec                        s2_p [3];
    tpc_pkg::t_dvec                       n_s1_diff [3];
    tpc_pkg::t_dvec                       r_s1_diff [3];
    logic signed [tpc_pkg::PROD_W-1:0]    n_s2_prod [3][3];
    logic signed [tpc_pkg::PROD_W-1:0]    r_s2_prod [3][3];
    logic signed [tpc_pkg::DIST_W-1:0]    sum [3];
    logic signed [tpc_pkg::DIST_W-1:0]    neg [3];
    logic [tpc_pkg::MAG_W-1:0]            mag [3];
    logic [2:0]                           ins;
    tpc_pkg::t_job                        n_s3_job;
    tpc_pkg::t_job                        r_s3_job;

    function automatic logic signed [tpc_pkg::PROD_W-1:0] smul(
        logic signed [tpc_pkg::DIFF_W-1:0] a,
        tpc_pkg::t_coord                    b
    );
        logic signed [tpc_pkg::PROD_W-1:0] ae;
        logic signed [tpc_pkg::PROD_W-1:0] be;
        ae = tpc_pkg::PROD_W'(a);
        be = tpc_pkg::PROD_W'(b);
        return ae * be;
    endfunction

    assign en      = !r_s3_v || !i_full;
    assign o_ready = en;
    assign o_push  = r_s3_v && !i_full;
    assign o_job   = r_s3_job;

    always_comb begin
        in_p[0] = '{i_item.vertex_a_x, i_item.vertex_a_y, i_item.vertex_a_z};
        in_p[1] = '{i_item.vertex_b_x, i_item.vertex_b_y, i_item.vertex_b_z};
        in_p[2] = '{i_item.vertex_c_x, i_item.vertex_c_y, i_item.vertex_c_z};
        s2_p[0] = '{r_s2_item.vertex_a_x, r_s2_item.vertex_a_y, r_s2_item.vertex_a_z};
        s2_p[1] = '{r_s2_item.vertex_b_x, r_s2_item.vertex_b_y, r_s2_item.vertex_b_z};
        s2_p[2] = '{r_s2_item.vertex_c_x, r_s2_item.vertex_c_y, r_s2_item.vertex_c_z};
        for (int v = 0; v < 3; v++) begin
            n_s1_diff[v]    = tpc_pkg::vsub(in_p[v], i_plane.point);
            n_s2_prod[v][0] = smul(r_s1_diff[v].x, i_plane.normal.x);
            n_s2_prod[v][1] = smul(r_s1_diff[v].y, i_plane.normal.y);
            n_s2_prod[v][2] = smul(r_s1_diff[v].z, i_plane.normal.z);
            sum[v] = tpc_pkg::DIST_W'(r_s2_prod[v][0]) + tpc_pkg::DIST_W'(r_s2_prod[v][1])
                   + tpc_pkg::DIST_W'(r_s2_prod[v][2]);
            neg[v] = -sum[v];
            ins[v] = !sum[v][tpc_pkg::DIST_W-1];
            mag[v] = ins[v] ? tpc_pkg::MAG_W'(sum[v]) : tpc_pkg::MAG_W'(neg[v]);
        end
    end

    // Vertex ordering per inside/outside pattern.
    always_comb begin
        n_s3_job      = '0;
        n_s3_job.attr = r_s2_item.attribute;
        unique case (ins)
            3'b111, 3'b000: begin
                n_s3_job.kind = tpc_pkg::KIND_PASS;
                n_s3_job.u    = s2_p[0];
                n_s3_job.w    = s2_p[1];
                n_s3_job.b1   = s2_p[2];
            end
            3'b110: begin
                n_s3_job.kind = tpc_pkg::KIND_TWO;
                n_s3_job.u    = s2_p[2];
                n_s3_job.w    = s2_p[1];
                n_s3_job.a2   = s2_p[1];
                n_s3_job.b1   = s2_p[0];
                n_s3_job.b2   = s2_p[0];
                n_s3_job.da1  = mag[2];
                n_s3_job.da2  = mag[1];
                n_s3_job.db1  = mag[0];
                n_s3_job.db2  = mag[0];
            end
            3'b101: begin
                n_s3_job.kind = tpc_pkg::KIND_TWO;
                n_s3_job.u    = s2_p[0];
                n_s3_job.w    = s2_p[2];
                n_s3_job.a2   = s2_p[2];
                n_s3_job.b1   = s2_p[1];
                n_s3_job.b2   = s2_p[1];
                n_s3_job.da1  = mag[0];
                n_s3_job.da2  = mag[2];
                n_s3_job.db1  = mag[1];
                n_s3_job.db2  = mag[1];
            end
            3'b011: begin
                n_s3_job.kind = tpc_pkg::KIND_TWO;
                n_s3_job.u    = s2_p[1];
                n_s3_job.w    = s2_p[0];
                n_s3_job.a2   = s2_p[0];
                n_s3_job.b1   = s2_p[2];
                n_s3_job.b2   = s2_p[2];
                n_s3_job.da1  = mag[1];
                n_s3_job.da2  = mag[0];
                n_s3_job.db1  = mag[2];
                n_s3_job.db2  = mag[2];
            end
            3'b001: begin
                n_s3_job.kind = tpc_pkg::KIND_ONE;
                n_s3_job.u    = s2_p[0];
                n_s3_job.w    = s2_p[1];
                n_s3_job.a2   = s2_p[0];
                n_s3_job.b1   = s2_p[1];
                n_s3_job.b2   = s2_p[2];
                n_s3_job.da1  = mag[0];
                n_s3_job.da2  = mag[0];
                n_s3_job.db1  = mag[1];
                n_s3_job.db2  = mag[2];
            end
            3'b010: begin
                n_s3_job.kind = tpc_pkg::KIND_ONE;
                n_s3_job.u    = s2_p[1];
                n_s3_job.w    = s2_p[2];
                n_s3_job.a2   = s2_p[1];
                n_s3_job.b1   = s2_p[2];
                n_s3_job.b2   = s2_p[0];
                n_s3_job.da1  = mag[1];
                n_s3_job.da2  = mag[1];
                n_s3_job.db1  = mag[2];
                n_s3_job.db2  = mag[0];
            end
            3'b100: begin
                n_s3_job.kind = tpc_pkg::KIND_ONE;
                n_s3_job.u    = s2_p[2];
                n_s3_job.w    = s2_p[0];
                n_s3_job.a2   = s2_p[2];
                n_s3_job.b1   = s2_p[0];
                n_s3_job.b2   = s2_p[1];
                n_s3_job.da1  = mag[2];
                n_s3_job.da2  = mag[2];
                n_s3_job.db1  = mag[0];
                n_s3_job.db2  = mag[1];
            end
        endcase
    end

    assign n_s3_v = r_s2_v && (ins != 3'b000);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= i_valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= n_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_item <= i_item;
            r_s2_item <= r_s1_item;
            r_s3_job  <= n_s3_job;
            r_s1_diff <= n_s1_diff;
            r_s2_prod <= n_s2_prod;
        end
    end

endmodule

FILE: hdl/tpc_fifo.sv
// ----------------------------------------------------------------------------
// tpc_fifo
// Short job queue between the classifier and the intersection back end.
// ----------------------------------------------------------------------------
module tpc_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  tpc_pkg::t_job      i_job,
    input  logic               i_pop,
    output tpc_pkg::t_job      o_job,
    output tpc_pkg::t_q_stat   o_stat
);

    tpc_pkg::t_job                r_mem [tpc_pkg::Q_DEPTH];
    logic [tpc_pkg::Q_AW-1:0]     r_wr;
    logic [tpc_pkg::Q_AW-1:0]     r_rd;
    logic [tpc_pkg::Q_CW-1:0]     r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    assign o_job        = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == tpc_pkg::Q_CW'(tpc_pkg::Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.count = r_cnt;

endmodule

FILE: hdl/tpc_div.sv
// ----------------------------------------------------------------------------
// tpc_div
// Two-lane restoring divider, one quotient bit per stage, one new pair of
// divisions per cycle while i_en is high. Carries the job context alongside.
// ----------------------------------------------------------------------------
module tpc_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  tpc_pkg::t_ctx             i_ctx,
    input  tpc_pkg::t_div_st          i_st1,
    input  tpc_pkg::t_div_st          i_st2,
    output logic                      o_valid,
    output tpc_pkg::t_ctx             o_ctx,
    output logic [tpc_pkg::T_W-1:0]   o_t1,
    output logic [tpc_pkg::T_W-1:0]   o_t2
);

    logic [tpc_pkg::T_W-1:0]   r_v;
    tpc_pkg::t_ctx             r_ctx [tpc_pkg::T_W];
    tpc_pkg::t_div_st          r_s1 [tpc_pkg::T_W];
    tpc_pkg::t_div_st          r_s2 [tpc_pkg::T_W];
    tpc_pkg::t_div_st          n_s1 [tpc_pkg::T_W];
    tpc_pkg::t_div_st          n_s2 [tpc_pkg::T_W];

    function automatic tpc_pkg::t_div_st div_step(tpc_pkg::t_div_st s);
        logic [tpc_pkg::DEN_W:0] sh;
        logic [tpc_pkg::DEN_W:0] dn;
        tpc_pkg::t_div_st        r;
        sh    = {s.rem, 1'b0};
        dn    = {1'b0, s.den};
        r.den = s.den;
        if (sh >= dn) begin
            r.rem = tpc_pkg::DEN_W'(sh - dn);
            r.q   = {s.q[tpc_pkg::T_W-2:0], 1'b1};
        end else begin
            r.rem = tpc_pkg::DEN_W'(sh);
            r.q   = {s.q[tpc_pkg::T_W-2:0], 1'b0};
        end
        return r;
    endfunction

    always_comb begin
        n_s1[0] = div_step(i_st1);
        n_s2[0] = div_step(i_st2);
        for (int k = 1; k < tpc_pkg::T_W; k++) begin
            n_s1[k] = div_step(r_s1[k-1]);
            n_s2[k] = div_step(r_s2[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[tpc_pkg::T_W-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1     <= n_s1;
            r_s2     <= n_s2;
            r_ctx[0] <= i_ctx;
            for (int k = 1; k < tpc_pkg::T_W; k++) begin
                r_ctx[k] <= r_ctx[k-1];
            end
        end
    end

    assign o_valid = r_v[tpc_pkg::T_W-1];
    assign o_ctx   = r_ctx[tpc_pkg::T_W-1];
    assign o_t1    = r_s1[tpc_pkg::T_W-1].q;
    assign o_t2    = r_s2[tpc_pkg::T_W-1].q;

endmodule

FILE: hdl/tpc_back.sv
// ----------------------------------------------------------------------------
// tpc_back
// Pops jobs, runs the edge divisions, scales the edge deltas, rounds and
// saturates, and hands out one or two result triangles per job.
// ----------------------------------------------------------------------------
module tpc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  tpc_pkg::t_job        i_job,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output tpc_pkg::t_out_item   o_item
);

    logic                            en;
    logic                            done;
    logic                            r_p_v;
    tpc_pkg::t_ctx                   r_p_ctx;
    tpc_pkg::t_ctx                   n_p_ctx;
    tpc_pkg::t_div_st                r_p_st1;
    tpc_pkg::t_div_st                r_p_st2;
    tpc_pkg::t_div_st                n_p_st1;
    tpc_pkg::t_div_st                n_p_st2;
    logic                            dv_v;
    tpc_pkg::t_ctx                   dv_ctx;
    logic [tpc_pkg::T_W-1:0]         dv_t1;
    logic [tpc_pkg::T_W-1:0]         dv_t2;
    logic                            r_m_v;
    tpc_pkg::t_ctx                   r_m_ctx;
    logic [tpc_pkg::MUL_W-1:0]       r_m_p1 [3];
    logic [tpc_pkg::MUL_W-1:0]       r_m_p2 [3];
    logic [tpc_pkg::MUL_W-1:0]       n_m_p1 [3];
    logic [tpc_pkg::MUL_W-1:0]       n_m_p2 [3];
    tpc_pkg::t_vec                   i1;
    tpc_pkg::t_vec                   i2;
    tpc_pkg::t_out_item              n_tri1;
    tpc_pkg::t_out_item              n_tri2;
    tpc_pkg::t_out_item              r_tri1;
    tpc_pkg::t_out_item              r_tri2;
    logic                            r_em_v;
    logic                            r_em_two;
    logic                            r_em_phase;

    function automatic logic [tpc_pkg::MUL_W-1:0] scale(
        logic signed [tpc_pkg::DIFF_W-1:0] d,
        logic [tpc_pkg::T_W-1:0]            t
    );
        logic signed [tpc_pkg::DIFF_W-1:0] a;
        logic [tpc_pkg::MUL_W-1:0]         me;
        logic [tpc_pkg::MUL_W-1:0]         te;
        a  = d[tpc_pkg::DIFF_W-1] ? -d : d;
        me = tpc_pkg::MUL_W'(a[tpc_pkg::CW-1:0]);
        te = tpc_pkg::MUL_W'(t);
        return me * te;
    endfunction

    function automatic tpc_pkg::t_coord isect(
        tpc_pkg::t_coord             a,
        logic                        neg,
        logic [tpc_pkg::MUL_W-1:0]   prod
    );
        logic [tpc_pkg::MUL_W:0]         rnd;
        logic [tpc_pkg::OFF_W-1:0]       off;
        logic signed [tpc_pkg::CW+1:0]   ae;
        logic signed [tpc_pkg::CW+1:0]   oe;
        logic signed [tpc_pkg::CW+1:0]   r;
        rnd = {1'b0, prod} + ({{tpc_pkg::MUL_W{1'b0}}, 1'b1} << (tpc_pkg::T_W - 1));
        off = rnd[tpc_pkg::MUL_W:tpc_pkg::T_W];
        ae  = (tpc_pkg::CW + 2)'(a);
        oe  = $signed({1'b0, off});
        r   = neg ? ae - oe : ae + oe;
        return tpc_pkg::sat_coord(r);
    endfunction

    function automatic tpc_pkg::t_out_item mk_out(
        tpc_pkg::t_vec                   a,
        tpc_pkg::t_vec                   b,
        tpc_pkg::t_vec                   c,
        logic [tpc_pkg::ATTR_W-1:0]      attr,
        logic                            last
    );
        tpc_pkg::t_out_item o;
        o.out_a_x       = a.x;
        o.out_a_y       = a.y;
        o.out_a_z       = a.z;
        o.out_b_x       = b.x;
        o.out_b_y       = b.y;
        o.out_b_z       = b.z;
        o.out_c_x       = c.x;
        o.out_c_y       = c.y;
        o.out_c_z       = c.z;
        o.out_attribute = attr;
        o.last_of_run   = last;
        return o;
    endfunction

    assign done  = r_em_v && i_ready && (r_em_phase || !r_em_two);
    assign en    = !r_em_v || done;
    assign o_pop = en && !i_empty;

    // Job setup: edge deltas and divider seeds.
    always_comb begin
        n_p_ctx.kind = i_job.kind;
        n_p_ctx.u    = i_job.u;
        n_p_ctx.w    = i_job.w;
        n_p_ctx.b1   = i_job.b1;
        n_p_ctx.a2   = i_job.a2;
        n_p_ctx.d1   = tpc_pkg::vsub(i_job.b1, i_job.u);
        n_p_ctx.d2   = tpc_pkg::vsub(i_job.b2, i_job.a2);
        n_p_ctx.attr = i_job.attr;
        n_p_st1.rem  = tpc_pkg::DEN_W'(i_job.da1);
        n_p_st1.den  = tpc_pkg::DEN_W'(i_job.da1) + tpc_pkg::DEN_W'(i_job.db1);
        n_p_st1.q    = '0;
        n_p_st2.rem  = tpc_pkg::DEN_W'(i_job.da2);
        n_p_st2.den  = tpc_pkg::DEN_W'(i_job.da2) + tpc_pkg::DEN_W'(i_job.db2);
        n_p_st2.q    = '0;
    end

    tpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_p_v),
        .i_ctx   (r_p_ctx),
        .i_st1   (r_p_st1),
        .i_st2   (r_p_st2),
        .o_valid (dv_v),
        .o_ctx   (dv_ctx),
        .o_t1    (dv_t1),
        .o_t2    (dv_t2)
    );

    always_comb begin
        n_m_p1[0] = scale(dv_ctx.d1.x, dv_t1);
        n_m_p1[1] = scale(dv_ctx.d1.y, dv_t1);
        n_m_p1[2] = scale(dv_ctx.d1.z, dv_t1);
        n_m_p2[0] = scale(dv_ctx.d2.x, dv_t2);
        n_m_p2[1] = scale(dv_ctx.d2.y, dv_t2);
        n_m_p2[2] = scale(dv_ctx.d2.z, dv_t2);
    end

    always_comb begin
        i1.x = isect(r_m_ctx.u.x, r_m_ctx.d1.x[tpc_pkg::DIFF_W-1], r_m_p1[0]);
        i1.y = isect(r_m_ctx.u.y, r_m_ctx.d1.y[tpc_pkg::DIFF_W-1], r_m_p1[1]);
        i1.z = isect(r_m_ctx.u.z, r_m_ctx.d1.z[tpc_pkg::DIFF_W-1], r_m_p1[2]);
        i2.x = isect(r_m_ctx.a2.x, r_m_ctx.d2.x[tpc_pkg::DIFF_W-1], r_m_p2[0]);
        i2.y = isect(r_m_ctx.a2.y, r_m_ctx.d2.y[tpc_pkg::DIFF_W-1], r_m_p2[1]);
        i2.z = isect(r_m_ctx.a2.z, r_m_ctx.d2.z[tpc_pkg::DIFF_W-1], r_m_p2[2]);
        unique case (r_m_ctx.kind)
            tpc_pkg::KIND_TWO: begin
                n_tri1 = mk_out(r_m_ctx.u, i1, r_m_ctx.w, r_m_ctx.attr, 1'b0);
                n_tri2 = mk_out(r_m_ctx.w, i1, i2, r_m_ctx.attr, 1'b1);
            end
            tpc_pkg::KIND_ONE: begin
                n_tri1 = mk_out(r_m_ctx.u, i1, i2, r_m_ctx.attr, 1'b1);
                n_tri2 = n_tri1;
            end
            default: begin
                n_tri1 = mk_out(r_m_ctx.u, r_m_ctx.w, r_m_ctx.b1, r_m_ctx.attr, 1'b1);
                n_tri2 = n_tri1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v      <= 1'b0;
            r_m_v      <= 1'b0;
            r_em_v     <= 1'b0;
            r_em_two   <= 1'b0;
            r_em_phase <= 1'b0;
        end else if (en) begin
            r_p_v      <= !i_empty;
            r_m_v      <= dv_v;
            r_em_v     <= r_m_v;
            r_em_two   <= (r_m_ctx.kind == tpc_pkg::KIND_TWO);
            r_em_phase <= 1'b0;
        end else if (r_em_v && i_ready) begin
            r_em_phase <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_ctx <= n_p_ctx;
            r_p_st1 <= n_p_st1;
            r_p_st2 <= n_p_st2;
            r_m_ctx <= dv_ctx;
            r_m_p1  <= n_m_p1;
            r_m_p2  <= n_m_p2;
            r_tri1  <= n_tri1;
            r_tri2  <= n_tri2;
        end
    end

    assign o_valid = r_em_v;
    assign o_item  = r_em_phase ? r_tri2 : r_tri1;

endmodule
